// ===== rtl/rfd_pkg.sv =====
// ---------------------------------------------------------------------------
// rfd_pkg
// Types and constants shared by the frame deframer and its channel interfaces.
// ---------------------------------------------------------------------------
package rfd_pkg;

   // Field widths
   localparam int unsigned BYTE_WIDTH     = 8;
   localparam int unsigned STATUS_WIDTH   = 2;
   localparam int unsigned FIELD_WIDTH    = 32;
   localparam int unsigned EXT_LEN_WIDTH  = 16;
   localparam int unsigned CSR_IDX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH = 8;

   // Frame layout: length byte, payload, checksum byte
   localparam int unsigned PAYLOAD_BYTES = 14;
   localparam int unsigned POS_WIDTH     = 4;
   localparam logic [POS_WIDTH-1:0] LAST_POSITION = POS_WIDTH'(PAYLOAD_BYTES + 1);
   localparam logic [BYTE_WIDTH-1:0] LENGTH_EXPECTED = BYTE_WIDTH'(PAYLOAD_BYTES);

   // Reset values of the header registers
   localparam logic [BYTE_WIDTH-1:0] HEADER_FIRST_RESET  = 8'd170;
   localparam logic [BYTE_WIDTH-1:0] HEADER_SECOND_RESET = 8'd85;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HEADER_FIRST  = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HEADER_SECOND = 1'b1;

   // Frame status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_LENGTH_ERROR = 2'd1,
      STATUS_SUM_ERROR    = 2'd2
   } status_type;

   // Sync state machine
   typedef enum logic [1:0] {
      PHASE_HUNT    = 2'd0,
      PHASE_FIRST   = 2'd1,
      PHASE_COLLECT = 2'd2
   } phase_type;

   typedef logic [BYTE_WIDTH-1:0] byte_type;

endpackage

// ===== rtl/rfd_req_if.sv =====
// ---------------------------------------------------------------------------
// rfd_req_if
// Received byte channel: valid/ready handshake carrying one byte per word.
// ---------------------------------------------------------------------------
interface rfd_req_if;
   import rfd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/rfd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rfd_rsp_if
// Decoded frame channel: status and the four telemetry fields per word.
// ---------------------------------------------------------------------------
interface rfd_rsp_if;
   import rfd_pkg::*;

   logic                            valid;
   logic                            ready;
   logic [STATUS_WIDTH-1:0]         status;
   logic signed [FIELD_WIDTH-1:0]   pitch_one;
   logic signed [FIELD_WIDTH-1:0]   pitch_two;
   logic signed [FIELD_WIDTH-1:0]   roll_value;
   logic [EXT_LEN_WIDTH-1:0]        extension_length;

   modport source (output valid, output status, output pitch_one, output pitch_two,
                   output roll_value, output extension_length, input ready);
   modport sink   (input valid, input status, input pitch_one, input pitch_two,
                   input roll_value, input extension_length, output ready);
endinterface

// ===== rtl/rx_frame_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// rx_frame_deframer_unit
// Hunts for a two-byte header in a byte stream, collects length, payload and
// checksum, and emits one decoded word per completed frame.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          rx_byte
//   rsp_chan  out  valid/ready          status, pitch_one, pitch_two,
//                                       roll_value, extension_length
//   csr_*     in   csr_write_en         csr_index, csr_write_data
//
// One byte per cycle; each byte is handled in the cycle it is accepted.
// A frame word appears in the output register the cycle after its checksum
// byte. Only the checksum byte waits on a full output register; every other
// byte is taken while a word still waits. Synchronous reset returns the
// block to hunting and restores the header registers to 170 and 85.
// ---------------------------------------------------------------------------
module rx_frame_deframer_unit (
   input  logic                                clock,
   input  logic                                reset,
   rfd_req_if.sink                             req_chan,
   rfd_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [rfd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [rfd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import rfd_pkg::*;

   // Header registers
   byte_type header_first_ff, header_first_in;
   byte_type header_second_ff, header_second_in;

   // Frame state
   phase_type               phase_ff, phase_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;
   byte_type                sum_ff, sum_in;
   byte_type                length_ff, length_in;
   byte_type                payload_ff [PAYLOAD_BYTES];
   byte_type                payload_in [PAYLOAD_BYTES];

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   status_type                    status_ff, status_in;
   logic signed [FIELD_WIDTH-1:0] pitch_one_ff, pitch_one_in;
   logic signed [FIELD_WIDTH-1:0] pitch_two_ff, pitch_two_in;
   logic signed [FIELD_WIDTH-1:0] roll_value_ff, roll_value_in;
   logic [EXT_LEN_WIDTH-1:0]      ext_len_ff, ext_len_in;

   logic     last_byte;
   logic     out_blocked;
   logic     accept;
   byte_type rx;

   // Only the checksum byte needs room in the output register
   assign last_byte      = (phase_ff == PHASE_COLLECT) && (pos_ff == LAST_POSITION);
   assign out_blocked    = rsp_valid_ff && !rsp_chan.ready;
   assign req_chan.ready = !(last_byte && out_blocked);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;

   // Decode register writes
   always_comb begin
      header_first_in  = header_first_ff;
      header_second_in = header_second_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  header_first_in  = csr_write_data;
            CSR_HEADER_SECOND: header_second_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // Sync state machine and collection
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      length_in  = length_ff;
      payload_in = payload_ff;
      if (accept) begin
         unique case (phase_ff)
            PHASE_FIRST: begin
               if (rx == header_second_ff) begin
                  phase_in = PHASE_COLLECT;
                  pos_in   = '0;
                  sum_in   = '0;
               end else if (rx == header_first_ff) begin
                  phase_in = PHASE_FIRST;
               end else begin
                  phase_in = PHASE_HUNT;
               end
            end
            PHASE_COLLECT: begin
               if (pos_ff != LAST_POSITION) begin
                  // Length byte first, then shift payload in from the top
                  if (pos_ff == '0) begin
                     length_in = rx;
                  end else begin
                     for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
                        payload_in[i] = payload_ff[i+1];
                     end
                     payload_in[PAYLOAD_BYTES-1] = rx;
                  end
                  sum_in = sum_ff + rx;
                  pos_in = pos_ff + 1'b1;
               end else begin
                  phase_in = PHASE_HUNT;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            default: begin
               phase_in = (rx == header_first_ff) ? PHASE_FIRST : PHASE_HUNT;
            end
         endcase
      end
   end

   // Load the frame word on the checksum byte, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      status_in     = status_ff;
      pitch_one_in  = pitch_one_ff;
      pitch_two_in  = pitch_two_ff;
      roll_value_in = roll_value_ff;
      ext_len_in    = ext_len_ff;
      if (accept && last_byte) begin
         rsp_valid_in  = 1'b1;
         pitch_one_in  = '0;
         pitch_two_in  = '0;
         roll_value_in = '0;
         ext_len_in    = '0;
         if (length_ff != LENGTH_EXPECTED) begin
            status_in = STATUS_LENGTH_ERROR;
         end else if (rx != sum_ff) begin
            status_in = STATUS_SUM_ERROR;
         end else begin
            status_in     = STATUS_OK;
            pitch_one_in  = {payload_ff[0], payload_ff[1], payload_ff[2], payload_ff[3]};
            pitch_two_in  = {payload_ff[4], payload_ff[5], payload_ff[6], payload_ff[7]};
            roll_value_in = {payload_ff[8], payload_ff[9], payload_ff[10], payload_ff[11]};
            ext_len_in    = {payload_ff[12], payload_ff[13]};
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
         phase_ff         <= PHASE_HUNT;
         pos_ff           <= '0;
         sum_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         header_first_ff  <= header_first_in;
         header_second_ff <= header_second_in;
         phase_ff         <= phase_in;
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      length_ff     <= length_in;
      payload_ff    <= payload_in;
      status_ff     <= status_in;
      pitch_one_ff  <= pitch_one_in;
      pitch_two_ff  <= pitch_two_in;
      roll_value_ff <= roll_value_in;
      ext_len_ff    <= ext_len_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.pitch_one        = pitch_one_ff;
   assign rsp_chan.pitch_two        = pitch_two_ff;
   assign rsp_chan.roll_value       = roll_value_ff;
   assign rsp_chan.extension_length = ext_len_ff;

   // A checksum byte always produces a word
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> rsp_valid_ff)
      else $error("checksum byte did not produce a frame word");

   // Position only moves while collecting
   a_pos_collect: assert property (@(posedge clock) disable iff (reset)
      pos_ff != '0 |-> phase_ff == PHASE_COLLECT)
      else $error("byte position set outside collection");

   // Failed frames carry zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_OK |->
         pitch_one_ff == '0 && pitch_two_ff == '0 && roll_value_ff == '0 &&
         ext_len_ff == '0)
      else $error("failed frame with nonzero fields");

   // A waiting word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_blocked |=> $stable(status_ff) && $stable(pitch_one_ff))
      else $error("waiting frame word overwritten");

endmodule
